// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FPOT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpot check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FPOT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpot check failed");

`endif

// ===== rtl/core/fpot_pkg.sv =====
// Types and constants shared by the orbit tracer modules.
package fpot_pkg;

    localparam int ORBIT_LIMIT   = 64;
    localparam int FRACTION_BITS = 28;
    localparam int SQRT_STEPS    = 32;
    localparam int SQRT_CNT_W    = $clog2(SQRT_STEPS);

    localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRACTION_BITS);

    localparam logic [31:0] K_REAL_RST   = 32'hFCCC_CCCD;  // about -0.2
    localparam logic [31:0] K_IMAG_RST   = 32'h0000_0000;
    localparam logic [6:0]  MAX_ITER_RST = 7'(ORBIT_LIMIT);

    localparam logic [1:0] CFG_K_REAL   = 2'd0;
    localparam logic [1:0] CFG_K_IMAG   = 2'd1;
    localparam logic [1:0] CFG_MAX_ITER = 2'd2;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_XX,
        MUL_YY,
        MUL_XSR,
        MUL_YSI,
        MUL_XSI,
        MUL_YSR
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        SQ_Q,
        SQ_A,
        SQ_B
    } sq_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MXX,
        ST_MYY,
        ST_QSUM,
        ST_EMIT,
        ST_WAIT_OUT,
        ST_SQM,
        ST_SQM_W,
        ST_SQA,
        ST_SQA_W,
        ST_SQB,
        ST_SQB_W,
        ST_RE1,
        ST_RE2,
        ST_RE3,
        ST_RE4,
        ST_IM1,
        ST_IM2
    } ctl_state_t;

    typedef struct packed {
        logic    load;
        mul_op_t mul_op;
        acc_op_t acc_op;
        logic    emit;
        logic    sq_start;
        logic    sq_take;
        sq_sel_t sq_sel;
        logic    take_re;
        logic    update;
    } dp_cmd_t;

    typedef struct packed {
        logic out_pend;
        logic stop;
        logic sq_done;
    } dp_status_t;

endpackage

// ===== rtl/core/fractal_power_orbit_tracer.sv =====
// Top level of the power-1.5 Julia orbit tracer.
//
//  channel | signals                                   | request moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid, in_ready, start_re, start_im     | one orbit start point
//  out     | out_valid, out_ready, point_re, point_im,  | one orbit point
//          | escaped, last                              |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | one register write
//
// One start point at a time. Each non-final orbit point goes through ten
// multiply/accumulate and control steps on one shared 32x32 multiplier, the out
// handshake, and three bit-serial square roots. No clearing pass after reset;
// cfg is always ready. A stalled out request holds the orbit until it is taken.
`include "assert_macros.svh"

module fractal_power_orbit_tracer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] start_re,
    input  logic signed [31:0] start_im,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] point_re,
    output logic signed [31:0] point_im,
    output logic               escaped,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    fpot_pkg::dp_cmd_t    cmd;
    fpot_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fpot_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fpot_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_re  (start_re),
        .start_im  (start_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_re  (point_re),
        .point_im  (point_im),
        .escaped   (escaped),
        .last      (last)
    );

    `FPOT_ASSERT_NOW(a_idle_no_pending, in_ready, !out_valid)
    `FPOT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    `FPOT_ASSERT_NOW(a_escape_ends_run, out_valid && escaped, last)
    `FPOT_ASSERT_NEXT(a_quiet_after_last, out_valid && out_ready && last, !out_valid)

endmodule

// ===== rtl/core/fpot_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module fpot_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] rad_reg,  rad_next;
    logic [34:0] rem_reg,  rem_next;
    logic [31:0] root_reg, root_next;
    logic [fpot_pkg::SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [34:0] rem_sh;
    logic [34:0] trial;

    always_comb
    begin
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fpot_pkg::SQRT_CNT_W'(fpot_pkg::SQRT_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/fpot_dp.sv =====
// Datapath: orbit point, shared multiplier, accumulator, square roots, config.
module fpot_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fpot_pkg::dp_cmd_t    cmd,
    output fpot_pkg::dp_status_t status,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic signed [31:0]   start_re,
    input  logic signed [31:0]   start_im,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   point_re,
    output logic signed [31:0]   point_im,
    output logic                 escaped,
    output logic                 last
);

    logic signed [31:0] k_real_reg, k_imag_reg;
    logic [6:0]         max_iter_reg;

    logic signed [31:0] x_reg, y_reg;
    logic signed [31:0] sr_reg, si_reg, nre_reg;
    logic [31:0]        m_reg;
    logic signed [63:0] prod_reg;
    logic signed [65:0] acc_reg;
    logic [6:0]         cnt_reg;
    logic               out_valid_reg, stop_reg;
    logic signed [31:0] ore_reg, oim_reg;
    logic               oesc_reg, olast_reg;

    logic signed [31:0] mul_a, mul_b;
    logic [6:0]         lim;
    logic               final_pt;
    logic               esc_now;
    logic [33:0]        sum_a, sum_b;
    logic [63:0]        sq_operand;
    logic               sq_done;
    logic [31:0]        sq_root;
    logic signed [65:0] shifted, with_k;
    logic signed [31:0] sat_val;

    fpot_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sq_start),
        .radicand (sq_operand),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_comb
    begin
        if (max_iter_reg == 7'd0)
            lim = 7'd1;
        else if (max_iter_reg > 7'(fpot_pkg::ORBIT_LIMIT))
            lim = 7'(fpot_pkg::ORBIT_LIMIT);
        else
            lim = max_iter_reg;
        final_pt = (cnt_reg + 7'd1) == lim;
        esc_now  = acc_reg[63:0] > fpot_pkg::ESC_LIMIT;
    end

    // half sum and half difference of modulus and real part, both known nonnegative
    always_comb
    begin
        sum_a = {2'b00, m_reg} + {{2{x_reg[31]}}, x_reg};
        sum_b = {2'b00, m_reg} - {{2{x_reg[31]}}, x_reg};
        unique case (cmd.sq_sel)
            fpot_pkg::SQ_Q: sq_operand = acc_reg[63:0];
            fpot_pkg::SQ_A: sq_operand = 64'(sum_a[33:1]) << fpot_pkg::FRACTION_BITS;
            fpot_pkg::SQ_B: sq_operand = 64'(sum_b[33:1]) << fpot_pkg::FRACTION_BITS;
            default:        sq_operand = acc_reg[63:0];
        endcase
    end

    always_comb
    begin
        unique case (cmd.mul_op)
            fpot_pkg::MUL_XX:  begin mul_a = x_reg; mul_b = x_reg;  end
            fpot_pkg::MUL_YY:  begin mul_a = y_reg; mul_b = y_reg;  end
            fpot_pkg::MUL_XSR: begin mul_a = x_reg; mul_b = sr_reg; end
            fpot_pkg::MUL_YSI: begin mul_a = y_reg; mul_b = si_reg; end
            fpot_pkg::MUL_XSI: begin mul_a = x_reg; mul_b = si_reg; end
            fpot_pkg::MUL_YSR: begin mul_a = y_reg; mul_b = sr_reg; end
            default:           begin mul_a = x_reg; mul_b = x_reg;  end
        endcase
    end

    // floor shift back to Q4.28, add k, clamp to 32 bits
    always_comb
    begin
        shifted = acc_reg >>> fpot_pkg::FRACTION_BITS;
        with_k  = shifted + 66'(k_real_reg);
        if (!cmd.take_re)
            with_k = shifted + 66'(k_imag_reg);
        if (with_k > 66'sd2147483647)
            sat_val = 32'sh7FFF_FFFF;
        else if (with_k < -66'sd2147483648)
            sat_val = 32'sh8000_0000;
        else
            sat_val = with_k[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_real_reg    <= fpot_pkg::K_REAL_RST;
            k_imag_reg    <= fpot_pkg::K_IMAG_RST;
            max_iter_reg  <= fpot_pkg::MAX_ITER_RST;
            out_valid_reg <= 1'b0;
            stop_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    fpot_pkg::CFG_K_REAL:   k_real_reg   <= cfg_data;
                    fpot_pkg::CFG_K_IMAG:   k_imag_reg   <= cfg_data;
                    fpot_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                stop_reg      <= esc_now || final_pt;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cmd.load)
                cnt_reg <= '0;
            else if (cmd.update)
                cnt_reg <= cnt_reg + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= start_re;
            y_reg <= start_im;
        end
        else if (cmd.update)
        begin
            x_reg <= nre_reg;
            y_reg <= sat_val;
        end
        if (cmd.mul_op != fpot_pkg::MUL_NONE)
            prod_reg <= mul_a * mul_b;
        unique case (cmd.acc_op)
            fpot_pkg::ACC_HOLD: acc_reg <= acc_reg;
            fpot_pkg::ACC_LOAD: acc_reg <= 66'(prod_reg);
            fpot_pkg::ACC_ADD:  acc_reg <= acc_reg + 66'(prod_reg);
            fpot_pkg::ACC_SUB:  acc_reg <= acc_reg - 66'(prod_reg);
            default:            acc_reg <= acc_reg;
        endcase
        if (cmd.sq_take)
        begin
            unique case (cmd.sq_sel)
                fpot_pkg::SQ_Q: m_reg  <= sq_root;
                fpot_pkg::SQ_A: sr_reg <= sq_root;
                fpot_pkg::SQ_B: si_reg <= y_reg[31] ? -sq_root : sq_root;
                default:        m_reg  <= sq_root;
            endcase
        end
        if (cmd.take_re)
            nre_reg <= sat_val;
        if (cmd.emit)
        begin
            ore_reg   <= x_reg;
            oim_reg   <= y_reg;
            oesc_reg  <= esc_now;
            olast_reg <= esc_now || final_pt;
        end
    end

    assign status.out_pend = out_valid_reg;
    assign status.stop     = stop_reg;
    assign status.sq_done  = sq_done;

    assign out_valid = out_valid_reg;
    assign point_re  = ore_reg;
    assign point_im  = oim_reg;
    assign escaped   = oesc_reg;
    assign last      = olast_reg;

endmodule

// ===== rtl/core/fpot_ctl.sv =====
// Controller: sequences one orbit iteration at a time through the datapath.
module fpot_ctl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  fpot_pkg::dp_status_t status,
    output fpot_pkg::dp_cmd_t    cmd
);

    fpot_pkg::ctl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpot_pkg::ST_IDLE:     if (in_valid) state_next = fpot_pkg::ST_MXX;
            fpot_pkg::ST_MXX:      state_next = fpot_pkg::ST_MYY;
            fpot_pkg::ST_MYY:      state_next = fpot_pkg::ST_QSUM;
            fpot_pkg::ST_QSUM:     state_next = fpot_pkg::ST_EMIT;
            fpot_pkg::ST_EMIT:     state_next = fpot_pkg::ST_WAIT_OUT;
            fpot_pkg::ST_WAIT_OUT:
            begin
                if (!status.out_pend)
                    state_next = status.stop ? fpot_pkg::ST_IDLE : fpot_pkg::ST_SQM;
            end
            fpot_pkg::ST_SQM:      state_next = fpot_pkg::ST_SQM_W;
            fpot_pkg::ST_SQM_W:    if (status.sq_done) state_next = fpot_pkg::ST_SQA;
            fpot_pkg::ST_SQA:      state_next = fpot_pkg::ST_SQA_W;
            fpot_pkg::ST_SQA_W:    if (status.sq_done) state_next = fpot_pkg::ST_SQB;
            fpot_pkg::ST_SQB:      state_next = fpot_pkg::ST_SQB_W;
            fpot_pkg::ST_SQB_W:    if (status.sq_done) state_next = fpot_pkg::ST_RE1;
            fpot_pkg::ST_RE1:      state_next = fpot_pkg::ST_RE2;
            fpot_pkg::ST_RE2:      state_next = fpot_pkg::ST_RE3;
            fpot_pkg::ST_RE3:      state_next = fpot_pkg::ST_RE4;
            fpot_pkg::ST_RE4:      state_next = fpot_pkg::ST_IM1;
            fpot_pkg::ST_IM1:      state_next = fpot_pkg::ST_IM2;
            fpot_pkg::ST_IM2:      state_next = fpot_pkg::ST_MXX;
            default:               state_next = fpot_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_op   = fpot_pkg::MUL_NONE;
        cmd.acc_op   = fpot_pkg::ACC_HOLD;
        cmd.sq_sel   = fpot_pkg::SQ_Q;
        in_ready     = 1'b0;
        unique case (state_reg)
            fpot_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            fpot_pkg::ST_MXX:  cmd.mul_op = fpot_pkg::MUL_XX;
            fpot_pkg::ST_MYY:
            begin
                cmd.mul_op = fpot_pkg::MUL_YY;
                cmd.acc_op = fpot_pkg::ACC_LOAD;
            end
            fpot_pkg::ST_QSUM: cmd.acc_op = fpot_pkg::ACC_ADD;
            fpot_pkg::ST_EMIT: cmd.emit   = 1'b1;
            fpot_pkg::ST_WAIT_OUT: ;
            fpot_pkg::ST_SQM:  cmd.sq_start = 1'b1;
            fpot_pkg::ST_SQM_W: cmd.sq_take = status.sq_done;
            fpot_pkg::ST_SQA:
            begin
                cmd.sq_sel   = fpot_pkg::SQ_A;
                cmd.sq_start = 1'b1;
            end
            fpot_pkg::ST_SQA_W:
            begin
                cmd.sq_sel  = fpot_pkg::SQ_A;
                cmd.sq_take = status.sq_done;
            end
            fpot_pkg::ST_SQB:
            begin
                cmd.sq_sel   = fpot_pkg::SQ_B;
                cmd.sq_start = 1'b1;
            end
            fpot_pkg::ST_SQB_W:
            begin
                cmd.sq_sel  = fpot_pkg::SQ_B;
                cmd.sq_take = status.sq_done;
            end
            fpot_pkg::ST_RE1:  cmd.mul_op = fpot_pkg::MUL_XSR;
            fpot_pkg::ST_RE2:
            begin
                cmd.mul_op = fpot_pkg::MUL_YSI;
                cmd.acc_op = fpot_pkg::ACC_LOAD;
            end
            fpot_pkg::ST_RE3:
            begin
                cmd.mul_op = fpot_pkg::MUL_XSI;
                cmd.acc_op = fpot_pkg::ACC_SUB;
            end
            fpot_pkg::ST_RE4:
            begin
                cmd.take_re = 1'b1;
                cmd.mul_op  = fpot_pkg::MUL_YSR;
                cmd.acc_op  = fpot_pkg::ACC_LOAD;
            end
            fpot_pkg::ST_IM1:  cmd.acc_op = fpot_pkg::ACC_ADD;
            fpot_pkg::ST_IM2:  cmd.update = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpot_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench for the power-1.5 Julia orbit tracer: directed and randomised requests, predicted orbits.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
    } start_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               esc;
        logic               fin;
    } orbit_pt_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] start_re = '0;
    logic signed [31:0] start_im = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] point_re;
    logic signed [31:0] point_im;
    logic escaped;
    logic last;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    fractal_power_orbit_tracer DUT (.*);

    // predictor's copy of the registers
    logic signed [31:0] kr_q = fpot_pkg::K_REAL_RST;
    logic signed [31:0] ki_q = fpot_pkg::K_IMAG_RST;
    logic [6:0]         iter_q = fpot_pkg::MAX_ITER_RST;

    start_t    start_q[$];
    orbit_pt_t orbit_q[$];
    int        n_err = 0;
    int        cycles = 0;
    bit        send_paused = 1'b0;
    int        gap_left = 0;
    int        hold_off = 0;
    bit        long_hold_req = 1'b0;
    int        in_flight = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint floor_fx(input longint v);
        return v >>> fpot_pkg::FRACTION_BITS;  // arithmetic shift floors
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic trace_orbit(input start_t s);
        longint x, y, si, sr, re, im, ax, ay;
        logic [63:0] q, m, a, b;
        int lim;
        orbit_pt_t p;
        x = s.re;
        y = s.im;
        lim = iter_q;
        if (lim < 1) lim = 1;
        if (lim > fpot_pkg::ORBIT_LIMIT) lim = fpot_pkg::ORBIT_LIMIT;
        for (int n = 0; n < lim; n++) begin
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            q = ax * ax + ay * ay;
            p.re = x[31:0];
            p.im = y[31:0];
            p.esc = q > fpot_pkg::ESC_LIMIT;
            p.fin = p.esc || (n + 1 == lim);
            orbit_q.insert(orbit_q.size(), p);
            if (p.esc) break;
            m = isqrt(q);
            a = (m + x) >> 1;
            b = (m - x) >> 1;
            sr = isqrt(a << fpot_pkg::FRACTION_BITS);
            si = isqrt(b << fpot_pkg::FRACTION_BITS);
            if (y < 0) si = -si;
            re = floor_fx(x * sr - y * si);
            im = floor_fx(x * si + y * sr);
            x = clamp32(re + kr_q);
            y = clamp32(im + ki_q);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_err++;
    endtask

    // driver: bursts with random gaps
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            trace_orbit('{re: start_re, im: start_im});
            in_flight--;
        end
        if (!(in_valid && !in_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (start_q.size() > 0 && !send_paused) begin
                in_valid <= 1'b1;
                start_re <= start_q[0].re;
                start_im <= start_q[0].im;
                void'(start_q.pop_front());
                if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 40);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req <= 1'b0;
            hold_off <= 3000;
            out_ready <= 1'b0;
        end else begin
            out_ready <= (cycles % 97 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // monitor
    always @(posedge clk) begin
        orbit_pt_t w;
        cycles <= cycles + 1;
        if (out_valid && out_ready) begin
            if (orbit_q.size() == 0) begin
                report("unexpected point", point_re, 0);
            end else begin
                w = orbit_q.pop_front();
                if (point_re !== w.re) report("point_re", point_re, w.re);
                if (point_im !== w.im) report("point_im", point_im, w.im);
                if (escaped !== w.esc) report("escaped", escaped, w.esc);
                if (last !== w.fin) report("last", last, w.fin);
            end
        end
        if (cycles > 20000000) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic queue_start(input logic [31:0] r, input logic [31:0] i);
        start_q.insert(start_q.size(), '{re: r, im: i});
        in_flight++;
    endtask

    task automatic drain();
        while (in_flight > 0 || orbit_q.size() > 0 || in_valid) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] d);
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            fpot_pkg::CFG_K_REAL:   kr_q = d;
            fpot_pkg::CFG_K_IMAG:   ki_q = d;
            fpot_pkg::CFG_MAX_ITER: iter_q = d[6:0];
            default: ;
        endcase
    endtask

    function automatic logic [31:0] rand_pt();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 | ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 0);
            default: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] ex[4];
        ex[0] = 32'h8000_0000; ex[1] = 32'h7FFF_FFFF; ex[2] = 0; ex[3] = 32'hF000_0000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed, reset settings: zero point, negative real axis, one off-axis point, extremes
        queue_start(0, 0);
        queue_start(32'hF800_0000, 0);
        queue_start(32'h0800_0000, 32'hF800_0000);
        for (int i = 0; i < 4; i++) queue_start(ex[i], ex[3 - i]);
        drain();
        write_reg(fpot_pkg::CFG_MAX_ITER, 0);
        write_reg(fpot_pkg::CFG_K_REAL, 32'h7FFF_FFFF);
        write_reg(fpot_pkg::CFG_K_IMAG, 32'h8000_0000);
        queue_start(0, 0);
        queue_start(32'h1000_0000, 32'h1000_0000);
        drain();
        write_reg(fpot_pkg::CFG_MAX_ITER, 7'd127);
        write_reg(fpot_pkg::CFG_K_REAL, 32'hF000_0000);
        write_reg(fpot_pkg::CFG_K_IMAG, 0);
        queue_start(0, 0);
        queue_start(32'hF000_0000, 0);
        drain();
        write_reg(2'd3, 32'h1);  // ignored index
        write_reg(fpot_pkg::CFG_MAX_ITER, 7'd2);
        queue_start(32'h0100_0000, 32'hFF00_0000);
        drain();
        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(fpot_pkg::CFG_K_REAL, ph == 7 ? 32'h8000_0000 : rand_pt());
            write_reg(fpot_pkg::CFG_K_IMAG, rand_pt());
            write_reg(fpot_pkg::CFG_MAX_ITER, ph == 0 ? 7'd64 : 7'($urandom_range(0, 20)));
            for (int i = 0; i < 27; i++) queue_start(rand_pt(), rand_pt());
            if (ph == 2) long_hold_req = 1'b1;
            if (ph == 4) begin
                while (start_q.size() > 13) @(posedge clk);
                send_paused = 1'b1;
                while (in_flight > start_q.size() || orbit_q.size() > 0) @(posedge clk);
                send_paused = 1'b0;
            end
            drain();
        end
        if (n_err == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end
endmodule
